// ===== rtl/lir_pkg.sv =====
package lir_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 21;
	localparam int NCH_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 21;
	localparam int RESULT_CAP = 64;
	localparam int RES_W      = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS       = 2'd2;

	localparam logic [STEP_W-1:0] STEP_RATIO_RST   = 21'd65536;
	localparam logic [NCH_W-1:0]  NUM_CHANNELS_RST = 2'd1;
	localparam logic              BYPASS_RST       = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] in_sample;
		logic                       block_start;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_sample;
		logic                       out_channel;
		logic                       out_last;
	} out_item_t;

	typedef struct packed {
		logic mul_en;
		logic add_en;
	} lerp_ctrl_t;

	typedef struct packed {
		logic wr_en;
		logic copy_en;
	} fs_ctrl_t;

endpackage

// ===== rtl/lir_frame_store.sv =====
module lir_frame_store #(
	parameter int MAX_CHANNELS = 2,
	parameter int CW           = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lir_pkg::fs_ctrl_t                   ctrl,
	input  logic [CW-1:0]                       wr_idx,
	input  logic signed [lir_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [CW-1:0]                       rd_idx,
	output logic signed [lir_pkg::SAMPLE_W-1:0] prev_rd,
	output logic signed [lir_pkg::SAMPLE_W-1:0] next_rd
);

	logic signed [lir_pkg::SAMPLE_W-1:0] prev_q [MAX_CHANNELS];
	logic signed [lir_pkg::SAMPLE_W-1:0] next_q [MAX_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				prev_q[i] <= '0;
				next_q[i] <= '0;
			end
		end else begin
			if (ctrl.wr_en) begin
				next_q[wr_idx] <= wr_data;
			end
			if (ctrl.copy_en) begin
				for (int i = 0; i < MAX_CHANNELS; i++) begin
					prev_q[i] <= (ctrl.wr_en && (wr_idx == CW'(i))) ? wr_data : next_q[i];
				end
			end
		end
	end

	assign prev_rd = prev_q[rd_idx];
	assign next_rd = next_q[rd_idx];

endmodule

// ===== rtl/lir_lerp_unit.sv =====
module lir_lerp_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  lir_pkg::lerp_ctrl_t                 ctrl,
	input  logic signed [lir_pkg::SAMPLE_W-1:0] a,
	input  logic signed [lir_pkg::SAMPLE_W-1:0] b,
	input  logic [FRAC_BITS-1:0]                frac,
	output logic signed [lir_pkg::SAMPLE_W-1:0] result
);

	localparam int DW = lir_pkg::SAMPLE_W + 1;
	localparam int PW = DW + FRAC_BITS + 1;
	localparam int NW = PW + 1;

	logic signed [PW-1:0]                diff_x;
	logic signed [PW-1:0]                frac_x;
	logic signed [PW-1:0]                prod_s1;
	logic signed [lir_pkg::SAMPLE_W-1:0] a_s1;
	logic signed [NW-1:0]                num;
	logic signed [NW-1:0]                quo;
	logic                                adj;
	logic signed [lir_pkg::SAMPLE_W-1:0] res_s2;

	assign diff_x = PW'(DW'(b) - DW'(a));
	assign frac_x = $signed(PW'({1'b0, frac}));

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= diff_x * frac_x;
			a_s1    <= a;
		end
	end

	// Arithmetic shift floors; a negative value with a nonzero remainder
	// moves up by one so the quotient truncates toward zero.
	always_comb begin
		num = (NW'(a_s1) <<< FRAC_BITS) + NW'(prod_s1);
		quo = num >>> FRAC_BITS;
		adj = num[NW-1] && (|num[FRAC_BITS-1:0]);
	end

	always_ff @(posedge clk) begin
		if (ctrl.add_en) begin
			res_s2 <= quo[lir_pkg::SAMPLE_W-1:0] + lir_pkg::SAMPLE_W'(adj);
		end
	end

	assign result = res_s2;

endmodule

// ===== rtl/linear_interp_resampler.sv =====
// Linear-interpolation sample-rate converter.
// Input channel (in_valid/in_ready/in_item): one interleaved signed sample per
// transfer, channels in order within a frame; block_start restarts the phase
// and forgets the stored frames. Output channel (out_valid/out_ready/out_item)
// carries the interpolated samples with their channel number; out_last marks
// the final sample caused by one input transfer. Configuration writes
// (cfg_valid/cfg_ready/cfg_index/cfg_data) are taken in any cycle and set the
// Q5.16 step ratio, the channel count and bypass.
// In bypass an input is registered and loads the output register once it is
// free; no new input is taken until then. Otherwise an input that completes
// a frame starts, for every output frame, a phase check and, per channel on
// the shared multiply-add unit, multiply, add and round, and output load,
// then a final phase check; up to 32 output frames follow one input frame.
// Inputs that leave a frame incomplete, or complete a frame that is skipped,
// are taken in the idle state. When the receiver stalls, the sequencer waits
// at the output load and the finished sample is held in the output register.
// Reset clears the stored frames, the phase and the frame position, empties
// the output register, and loads the configuration defaults (unity step, one
// channel, bypass on).
module linear_interp_resampler #(
	parameter int MAX_CHANNELS = 2,
	parameter int FRAC_BITS    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lir_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lir_pkg::out_item_t                  out_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lir_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lir_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W  = CW + 1;
	localparam int FW     = ((FRAC_BITS > lir_pkg::STEP_W) ? FRAC_BITS : lir_pkg::STEP_W) + 1;
	localparam int SKW    = FW - FRAC_BITS;
	localparam int NCNT_W = lir_pkg::RES_W + 1;
	localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;

	localparam logic [FW-1:0] ONE_F    = FW'(1) << FRAC_BITS;
	localparam logic [FW-1:0] STEP_MIN = FW'(1) << (FRAC_BITS - 5);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BYP  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_PUSH = 3'd5;

	logic [2:0]                          state_q;
	logic [lir_pkg::STEP_W-1:0]          step_ratio_q;
	logic [lir_pkg::NCH_W-1:0]           num_channels_q;
	logic                                bypass_q;
	logic                                have_prev_q;
	logic [CW-1:0]                       chan_count_q;
	logic [FRAC_BITS-1:0]                phase_q;
	logic [SKW-1:0]                      skip_q;
	logic [FW-1:0]                       f_q;
	logic [CW-1:0]                       c_q;
	logic [lir_pkg::RES_W-1:0]           n_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] sample_q;
	logic [CW-1:0]                       pos_q;
	logic                                out_valid_q;
	lir_pkg::out_item_t                  out_q;

	logic [lir_pkg::NCH_W-1:0]           nch;
	logic                                acc;
	logic                                hp_eff;
	logic [CW-1:0]                       cc_eff;
	logic [FRAC_BITS-1:0]                ph_eff;
	logic [SKW-1:0]                      sk_eff;
	logic [CNT_W-1:0]                    cc_inc;
	logic                                frame_end;
	logic                                start_run;
	logic [FW-1:0]                       step_x;
	logic [FW-1:0]                       step_e;
	logic [FW-1:0]                       f_next;
	logic                                f_done;
	logic                                fits;
	logic                                c_last;
	logic                                last_res;
	logic                                out_free;
	logic                                load_byp;
	logic                                load_run;
	lir_pkg::fs_ctrl_t                   fs_ctrl;
	lir_pkg::lerp_ctrl_t                 lerp_ctrl;
	logic signed [lir_pkg::SAMPLE_W-1:0] prev_rd;
	logic signed [lir_pkg::SAMPLE_W-1:0] next_rd;
	logic signed [lir_pkg::SAMPLE_W-1:0] lerp_res;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		if (num_channels_q == '0) begin
			nch = lir_pkg::NCH_W'(1);
		end else if (CMP_W'(num_channels_q) > CMP_W'(MAX_CHANNELS)) begin
			nch = lir_pkg::NCH_W'(MAX_CHANNELS);
		end else begin
			nch = num_channels_q;
		end
	end

	always_comb begin
		hp_eff    = in_item.block_start ? 1'b0 : have_prev_q;
		cc_eff    = in_item.block_start ? '0 : chan_count_q;
		ph_eff    = in_item.block_start ? '0 : phase_q;
		sk_eff    = in_item.block_start ? '0 : skip_q;
		cc_inc    = CNT_W'(cc_eff) + CNT_W'(1);
		frame_end = CMP_W'(cc_inc) >= CMP_W'(nch);
		start_run = hp_eff && (sk_eff == '0);
		step_x    = FW'(step_ratio_q);
		step_e    = (step_x < STEP_MIN) ? STEP_MIN : step_x;
		f_next    = f_q + step_e;
		f_done    = f_q >= ONE_F;
		fits      = (NCNT_W'(n_q) + NCNT_W'(nch)) <= NCNT_W'(lir_pkg::RESULT_CAP);
		c_last    = (CMP_W'(c_q) + CMP_W'(1)) >= CMP_W'(nch);
		last_res  = c_last && ((f_next >= ONE_F) ||
			((NCNT_W'(n_q) + NCNT_W'(1) + NCNT_W'(nch)) > NCNT_W'(lir_pkg::RESULT_CAP)));
		load_byp  = (state_q == ST_BYP) && out_free;
		load_run  = (state_q == ST_PUSH) && out_free;
	end

	always_comb begin
		fs_ctrl.wr_en     = acc && !bypass_q;
		fs_ctrl.copy_en   = (acc && !bypass_q && frame_end && !start_run) ||
			((state_q == ST_CHK) && f_done);
		lerp_ctrl.mul_en  = (state_q == ST_MUL);
		lerp_ctrl.add_en  = (state_q == ST_ADD);
	end

	lir_frame_store #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.CW          (CW)
	) u_frames (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fs_ctrl),
		.wr_idx (cc_eff),
		.wr_data(in_item.in_sample),
		.rd_idx (c_q),
		.prev_rd(prev_rd),
		.next_rd(next_rd)
	);

	lir_lerp_unit #(
		.FRAC_BITS(FRAC_BITS)
	) u_lerp (
		.clk   (clk),
		.ctrl  (lerp_ctrl),
		.a     (prev_rd),
		.b     (next_rd),
		.frac  (f_q[FRAC_BITS-1:0]),
		.result(lerp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ratio_q   <= lir_pkg::STEP_RATIO_RST;
			num_channels_q <= lir_pkg::NUM_CHANNELS_RST;
			bypass_q       <= lir_pkg::BYPASS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lir_pkg::CFG_STEP_RATIO: begin
					step_ratio_q <= cfg_data;
				end
				lir_pkg::CFG_NUM_CHANNELS: begin
					num_channels_q <= cfg_data[lir_pkg::NCH_W-1:0];
				end
				lir_pkg::CFG_BYPASS: begin
					bypass_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			have_prev_q  <= 1'b0;
			chan_count_q <= '0;
			phase_q      <= '0;
			skip_q       <= '0;
			f_q          <= '0;
			c_q          <= '0;
			n_q          <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						phase_q      <= ph_eff;
						chan_count_q <= frame_end ? '0 : cc_inc[CW-1:0];
						if (bypass_q) begin
							have_prev_q <= hp_eff;
							skip_q      <= sk_eff;
							state_q     <= ST_BYP;
						end else if (frame_end && start_run) begin
							have_prev_q <= hp_eff;
							skip_q      <= sk_eff;
							f_q         <= FW'(ph_eff);
							n_q         <= '0;
							state_q     <= ST_CHK;
						end else if (frame_end) begin
							have_prev_q <= 1'b1;
							skip_q      <= hp_eff ? (sk_eff - SKW'(1)) : sk_eff;
						end else begin
							have_prev_q <= hp_eff;
							skip_q      <= sk_eff;
						end
					end
				end
				ST_BYP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHK: begin
					if (f_done) begin
						skip_q      <= f_q[FW-1:FRAC_BITS] - SKW'(1);
						phase_q     <= f_q[FRAC_BITS-1:0];
						have_prev_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (fits) begin
						c_q     <= '0;
						state_q <= ST_MUL;
					end else begin
						f_q <= f_next;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_free) begin
						n_q <= n_q + lir_pkg::RES_W'(1);
						if (c_last) begin
							f_q     <= f_next;
							state_q <= ST_CHK;
						end else begin
							c_q     <= c_q + CW'(1);
							state_q <= ST_MUL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sample_q <= in_item.in_sample;
			pos_q    <= cc_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_byp || load_run) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_byp) begin
			out_q.out_sample  <= sample_q;
			out_q.out_channel <= pos_q[0];
			out_q.out_last    <= 1'b1;
		end else if (load_run) begin
			out_q.out_sample  <= lerp_res;
			out_q.out_channel <= c_q[0];
			out_q.out_last    <= last_res;
		end
	end

`ifndef SYNTHESIS
	a_phase_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (f_q < ONE_F))
		else $error("interpolation issued with phase at or above one");

	a_skip_needs_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(skip_q != '0) |-> have_prev_q)
		else $error("pending frame skip without a previous frame");

	a_chan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) |-> (CMP_W'(c_q) < CMP_W'(nch)))
		else $error("output channel beyond the active channel count");

	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		load_run |-> (NCNT_W'(n_q) < NCNT_W'(lir_pkg::RESULT_CAP)))
		else $error("result count past the cap for one input");

	a_frame_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (CMP_W'(chan_count_q) < CMP_W'(MAX_CHANNELS)))
		else $error("frame position beyond the channel storage");
`endif

endmodule
